@@ rtl/core/stable_pattern_capture_detector_assert.svh @@
// Assertion macros used by the stable pattern capture detector control module.
`ifndef STABLE_PATTERN_CAPTURE_DETECTOR_ASSERT_SVH
`define STABLE_PATTERN_CAPTURE_DETECTOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SPCD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define SPCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/core/scd_pkg.sv @@
// Shared constants and control types of the stable pattern capture detector.
package scd_pkg;

    localparam int WINDOW_DEPTH = 64;
    localparam int ADDR_W = $clog2(WINDOW_DEPTH);
    localparam int N_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W = 16 + N_W;
    localparam int SQ_W = 32 + N_W;
    localparam int WIDE_W = 2 * N_W + 32;
    localparam int TN_W = 16 + N_W;
    localparam int STAMP_W = 27;
    localparam int ENTRY_W = STAMP_W + 1 + 16 + 16;
    localparam int RATE_MAX = 63;

    localparam logic [1:0] REG_TIMESPAN = 2'd0;
    localparam logic [1:0] REG_MIN_FRAMES = 2'd1;
    localparam logic [1:0] REG_SPREAD = 2'd2;

    typedef struct packed {
        logic start;
        logic ev;
        logic mul1;
        logic mul2;
        logic finish;
    } scd_cmd_t;

    typedef struct packed {
        logic walk_done;
        logic out_busy;
    } scd_status_t;

endpackage

@@ rtl/core/scd_ctrl.sv @@
// Sequencing state machine of the stable pattern capture detector.
module scd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  scd_pkg::scd_status_t status,
    output scd_pkg::scd_cmd_t    cmd
);
    import scd_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_EV,
        ST_MUL1,
        ST_MUL2,
        ST_FIN
    } state_t;

    state_t state_reg;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd = '0;
        cmd.start = (state_reg == ST_IDLE) && in_valid;
        cmd.ev = (state_reg == ST_EV);
        cmd.mul1 = (state_reg == ST_MUL1);
        cmd.mul2 = (state_reg == ST_MUL2);
        cmd.finish = (state_reg == ST_FIN) && !status.out_busy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= ST_RD;
                    end
                end
                ST_RD:
                begin
                    state_reg <= ST_EV;
                end
                ST_EV:
                begin
                    state_reg <= status.walk_done ? ST_MUL1 : ST_RD;
                end
                ST_MUL1:
                begin
                    state_reg <= ST_MUL2;
                end
                ST_MUL2:
                begin
                    state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    if (!status.out_busy)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`include "stable_pattern_capture_detector_assert.svh"

    `SPCD_ASSERT_NEXT(a_accept_starts_walk, clk, rst_n, in_valid && in_ready, state_reg == ST_RD)
    `SPCD_ASSERT_NEXT(a_walk_continues, clk, rst_n, state_reg == ST_EV && !status.walk_done, state_reg == ST_RD)
    `SPCD_ASSERT_NOW(a_finish_when_free, clk, rst_n, cmd.finish, !status.out_busy && !in_ready)

endmodule

@@ rtl/core/scd_dp.sv @@
// Window memory, span walk accumulators, variance test and result register.
module scd_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  scd_pkg::scd_cmd_t    cmd,
    output scd_pkg::scd_status_t status,
    input  logic [15:0]          timespan_ms,
    input  logic [5:0]           min_frames,
    input  logic [15:0]          spread_limit,
    input  logic [26:0]          timestamp_ms,
    input  logic                 pattern_found,
    input  logic [15:0]          center_x,
    input  logic [15:0]          center_y,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 capture,
    output logic [5:0]           rough_rate,
    output logic [15:0]          capture_count,
    output logic [31:0]          frame_total
);
    import scd_pkg::*;

    localparam int BIG_W = ADDR_W + 6;

    logic [ENTRY_W-1:0] mem [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0] valid_reg;
    logic [ENTRY_W-1:0] rd_entry_reg;
    logic rd_valid_reg;

    logic [ADDR_W-1:0] head_reg;
    logic [ADDR_W-1:0] head_next;
    logic [ADDR_W-1:0] idx_reg;
    logic [ADDR_W-1:0] bound_reg;
    logic [ADDR_W-1:0] raddr;
    logic [ADDR_W:0] raddr_wide;
    logic hit_reg;
    logic all_reg;
    logic [STAMP_W-1:0] newest_reg;
    logic [SUM_W-1:0] sx_reg;
    logic [SUM_W-1:0] sy_reg;
    logic [SQ_W-1:0] qx_reg;
    logic [SQ_W-1:0] qy_reg;
    logic [WIDE_W-1:0] nqx_reg;
    logic [WIDE_W-1:0] nqy_reg;
    logic [WIDE_W-1:0] ssx_reg;
    logic [WIDE_W-1:0] ssy_reg;
    logic [TN_W-1:0] tn_reg;
    logic [WIDE_W-1:0] lhsx_reg;
    logic [WIDE_W-1:0] lhsy_reg;
    logic [WIDE_W-1:0] rhs_reg;

    logic out_valid_reg;
    logic capture_reg;
    logic [5:0] rate_reg;
    logic [15:0] capcnt_reg;
    logic [31:0] frame_reg;

    logic [STAMP_W-1:0] t_cur;
    logic [15:0] x_cur;
    logic [15:0] y_cur;
    logic f_cur;
    logic empty_slot;
    logic older;
    logic last_slot;
    logic walk_done;
    logic [N_W-1:0] n_val;
    logic [BIG_W-1:0] bound_big;
    logic pass_min;
    logic steady;
    logic do_capture;
    logic [5:0] rate_sat;

    assign head_next = (head_reg == ADDR_W'(WINDOW_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign raddr_wide = ({1'b0, head_reg} >= {1'b0, idx_reg})
        ? ({1'b0, head_reg} - {1'b0, idx_reg})
        : ({1'b0, head_reg} + (ADDR_W + 1)'(WINDOW_DEPTH) - {1'b0, idx_reg});
    assign raddr = raddr_wide[ADDR_W-1:0];

    assign t_cur = rd_valid_reg ? rd_entry_reg[ENTRY_W-1 -: STAMP_W] : '0;
    assign f_cur = rd_entry_reg[32];
    assign x_cur = rd_entry_reg[31:16];
    assign y_cur = rd_entry_reg[15:0];
    assign empty_slot = (t_cur == '0);
    assign older = (newest_reg > t_cur)
        && ((newest_reg - t_cur) > STAMP_W'(timespan_ms));
    assign last_slot = (idx_reg == ADDR_W'(WINDOW_DEPTH - 1));
    assign walk_done = empty_slot || older || last_slot;

    assign n_val = N_W'(bound_reg) + 1'b1;
    assign bound_big = BIG_W'(bound_reg);
    assign pass_min = hit_reg && (bound_big >= BIG_W'(min_frames));
    assign steady = (lhsx_reg < rhs_reg) && (lhsy_reg < rhs_reg);
    assign do_capture = pass_min && all_reg && steady;
    assign rate_sat = (bound_big > BIG_W'(RATE_MAX)) ? 6'(RATE_MAX) : bound_big[5:0];

    assign status.walk_done = walk_done;
    assign status.out_busy = out_valid_reg && !out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            mem[head_next] <= {timestamp_ms, pattern_found, center_x, center_y};
        end
        rd_entry_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_valid_reg <= 1'b0;
            head_reg <= '0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[raddr];
            if (cmd.start)
            begin
                valid_reg[head_next] <= 1'b1;
                head_reg <= head_next;
            end
            else if (cmd.finish && do_capture)
            begin
                valid_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            idx_reg <= ADDR_W'(1);
            hit_reg <= 1'b0;
            bound_reg <= '0;
            all_reg <= pattern_found;
            newest_reg <= timestamp_ms;
            sx_reg <= SUM_W'(center_x);
            sy_reg <= SUM_W'(center_y);
            qx_reg <= SQ_W'(center_x * center_x);
            qy_reg <= SQ_W'(center_y * center_y);
        end
        else if (cmd.ev)
        begin
            if (!empty_slot)
            begin
                all_reg <= all_reg & f_cur;
                sx_reg <= sx_reg + SUM_W'(x_cur);
                sy_reg <= sy_reg + SUM_W'(y_cur);
                qx_reg <= qx_reg + SQ_W'(x_cur * x_cur);
                qy_reg <= qy_reg + SQ_W'(y_cur * y_cur);
            end
            if (!empty_slot && older)
            begin
                hit_reg <= 1'b1;
                bound_reg <= idx_reg;
            end
            if (!walk_done)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
        if (cmd.mul1)
        begin
            nqx_reg <= WIDE_W'(n_val) * WIDE_W'(qx_reg);
            nqy_reg <= WIDE_W'(n_val) * WIDE_W'(qy_reg);
            ssx_reg <= WIDE_W'(sx_reg) * WIDE_W'(sx_reg);
            ssy_reg <= WIDE_W'(sy_reg) * WIDE_W'(sy_reg);
            tn_reg <= TN_W'(spread_limit) * TN_W'(n_val);
        end
        if (cmd.mul2)
        begin
            lhsx_reg <= nqx_reg - ssx_reg;
            lhsy_reg <= nqy_reg - ssy_reg;
            rhs_reg <= WIDE_W'(tn_reg) * WIDE_W'(tn_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            capture_reg <= 1'b0;
            rate_reg <= '0;
            capcnt_reg <= '0;
            frame_reg <= '0;
        end
        else
        begin
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
                capture_reg <= do_capture;
                frame_reg <= frame_reg + 1'b1;
                if (pass_min)
                begin
                    rate_reg <= rate_sat;
                end
                if (do_capture)
                begin
                    capcnt_reg <= capcnt_reg + 1'b1;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign capture = capture_reg;
    assign rough_rate = rate_reg;
    assign capture_count = capcnt_reg;
    assign frame_total = frame_reg;

endmodule

@@ rtl/core/stable_pattern_capture_detector.sv @@
// Top level of the stable pattern capture detector with its register port.
// Each frame word is written into a 64-entry window memory and the block then walks the
// window from the newest frame backward, one entry at a time through the memory's
// single registered read port, summing centers until it meets an empty slot, a frame
// older than the time span or the end of the window. It walks 1 to 63 entries per frame
// and takes no new frame during a walk; a result word is produced for every frame and
// a new frame is taken while the previous result still waits, but the new result is held
// back until the previous one has been taken.
module stable_pattern_capture_detector (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [26:0] timestamp_ms,
    input  logic        pattern_found,
    input  logic [15:0] center_x,
    input  logic [15:0] center_y,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        capture,
    output logic [5:0]  rough_rate,
    output logic [15:0] capture_count,
    output logic [31:0] frame_total
);
    import scd_pkg::*;

    logic [15:0] timespan_reg;
    logic [5:0] min_frames_reg;
    logic [15:0] spread_reg;
    logic wr_en;
    scd_cmd_t cmd;
    scd_status_t status;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timespan_reg <= 16'd1000;
            min_frames_reg <= 6'd10;
            spread_reg <= 16'd32;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_TIMESPAN:   timespan_reg <= pwdata[15:0];
                REG_MIN_FRAMES: min_frames_reg <= pwdata[5:0];
                REG_SPREAD:     spread_reg <= pwdata[15:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_TIMESPAN:   prdata = {16'd0, timespan_reg};
            REG_MIN_FRAMES: prdata = {26'd0, min_frames_reg};
            REG_SPREAD:     prdata = {16'd0, spread_reg};
            default:        prdata = '0;
        endcase
    end

    scd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    scd_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .timespan_ms   (timespan_reg),
        .min_frames    (min_frames_reg),
        .spread_limit  (spread_reg),
        .timestamp_ms  (timestamp_ms),
        .pattern_found (pattern_found),
        .center_x      (center_x),
        .center_y      (center_y),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .capture       (capture),
        .rough_rate    (rough_rate),
        .capture_count (capture_count),
        .frame_total   (frame_total)
    );

endmodule
